// ===== hw/rtl/cnm_pkg.sv =====
`timescale 1ns / 1ps

package cnm_pkg;

	// Datapath widths
	localparam int TIME_W     = 42;  // signed seconds, room for the search window and a backward first step
	localparam int DELTA_W    = 23;  // signed seconds moved by one search step
	localparam int YEAR_W     = 13;  // full year plus the carries of a long search
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 60;

	localparam int SECS_PER_DAY  = 86400;
	localparam int SECS_PER_HOUR = 3600;
	localparam int SECS_PER_MIN  = 60;

	localparam logic signed [DELTA_W-1:0] DAY_SECS_S  = DELTA_W'(SECS_PER_DAY);
	localparam logic signed [DELTA_W-1:0] HOUR_SECS_S = DELTA_W'(SECS_PER_HOUR);
	localparam logic signed [DELTA_W-1:0] MIN_SECS_S  = DELTA_W'(SECS_PER_MIN);

	// Reciprocal of 25 for the century test, exact for every 13-bit year
	localparam int RECIP_25       = 5243;
	localparam int RECIP_25_SHIFT = 17;

	// Calendar codes
	localparam logic [3:0] MONTHS_PER_YEAR = 4'd12;
	localparam logic [3:0] MON_FEB = 4'd1;
	localparam logic [3:0] MON_APR = 4'd3;
	localparam logic [3:0] MON_JUN = 4'd5;
	localparam logic [3:0] MON_SEP = 4'd8;
	localparam logic [3:0] MON_NOV = 4'd10;
	localparam logic [5:0] HOURS_PER_DAY = 6'd24;
	localparam logic [5:0] LAST_MINUTE   = 6'd59;
	localparam logic [2:0] DAYS_PER_WEEK = 3'd7;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MINUTE_MASK    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOUR_MASK      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MONTH_DAY_MASK = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WEEKDAY_MASK   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MONTH_MASK     = 3'd4;

	localparam logic [59:0] MINUTE_MASK_RST    = 60'hFFF_FFFF_FFFF_FFFF;
	localparam logic [23:0] HOUR_MASK_RST      = 24'hFF_FFFF;
	localparam logic [31:0] MONTH_DAY_MASK_RST = 32'hFFFF_FFFE;
	localparam logic [6:0]  WEEKDAY_MASK_RST   = 7'h7F;
	localparam logic [11:0] MONTH_MASK_RST     = 12'hFFF;

	typedef struct packed {
		logic [39:0] start_time;
		logic [11:0] start_year;
		logic [3:0]  start_month;
		logic [4:0]  start_mday;
		logic [2:0]  start_wday;
		logic [4:0]  start_hour;
		logic [5:0]  start_minute;
		logic [5:0]  start_second;
	} cnm_in_t;

	typedef struct packed {
		logic        found;
		logic [39:0] next_time;
		logic [11:0] next_year;
		logic [3:0]  next_month;
		logic [4:0]  next_mday;
		logic [2:0]  next_wday;
		logic [4:0]  next_hour;
		logic [5:0]  next_minute;
	} cnm_out_t;

	typedef struct packed {
		logic [59:0] minute_mask;
		logic [23:0] hour_mask;
		logic [31:0] month_day_mask;
		logic [6:0]  weekday_mask;
		logic [11:0] month_mask;
	} masks_t;

	typedef struct packed {
		logic [YEAR_W-1:0] year;
		logic              leap;
		logic [3:0]        mon;
		logic [4:0]        mday;
		logic [2:0]        wday;
		logic [4:0]        hour;
		logic [5:0]        minute;
	} cal_t;

	typedef enum logic [2:0] {
		STEP_MATCH,
		STEP_MONTH,
		STEP_DAY,
		STEP_HOUR,
		STEP_MINUTE
	} step_kind_t;

	typedef struct packed {
		step_kind_t                  kind;
		logic signed [DELTA_W-1:0]   delta;
	} step_t;

	// Gregorian leap test: divisible by 4, and centuries only when divisible by 400
	function automatic logic is_leap(input logic [YEAR_W-1:0] y);
		logic [26:0]       prod;
		logic [YEAR_W-1:0] q;
		logic [YEAR_W-1:0] r;
		prod = 27'(y) * 27'(RECIP_25);
		q = YEAR_W'(prod >> RECIP_25_SHIFT);
		r = y - YEAR_W'(q * YEAR_W'(25));
		return (y[1:0] == 2'd0) && ((r != '0) || (y[3:0] == 4'd0));
	endfunction

	// Days in a month; codes past December count as 31-day months
	function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
		logic [4:0] len;
		case (mon)
			MON_FEB: len = leap ? 5'd29 : 5'd28;
			MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

	// Remainder by 7 for values below 49
	function automatic logic [2:0] mod7(input logic [5:0] v);
		logic [5:0] r;
		r = v;
		for (int i = 0; i < 6; i++) begin
			if (r >= 6'(DAYS_PER_WEEK)) begin
				r = r - 6'(DAYS_PER_WEEK);
			end
		end
		return r[2:0];
	endfunction

endpackage

// ===== hw/rtl/cnm_stream_if.sv =====
`timescale 1ns / 1ps

interface cnm_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

// ===== hw/rtl/cnm_cal_step.sv =====
`timescale 1ns / 1ps

module cnm_cal_step (
	input  cnm_pkg::cal_t   cal,
	input  cnm_pkg::masks_t masks,
	output cnm_pkg::step_t  step,
	output cnm_pkg::cal_t   nxt
);

	localparam int DW = cnm_pkg::DELTA_W;
	localparam int YW = cnm_pkg::YEAR_W;

	logic [15:0] mon_vec;
	logic [31:0] hour_vec;
	logic [63:0] min_vec;
	logic [7:0]  wday_vec;
	logic        mon_hit, day_hit, hour_hit, min_hit;
	logic [4:0]  mlen;
	logic [6:0]  days_u;
	logic signed [DW-1:0] day_part, hour_part, min_part;
	logic        min_roll, do_hour, do_day, do_month;
	logic [5:0]  hour_inc, mday_inc, min_inc;
	logic [4:0]  mon_inc;
	logic        hour_roll, mday_roll, year_roll;
	logic        leap_next;
	cnm_pkg::step_kind_t  kind;
	logic signed [DW-1:0] delta;

	// Widen masks so out-of-range field values read as misses
	assign mon_vec  = {4'b0, masks.month_mask};
	assign hour_vec = {8'b0, masks.hour_mask};
	assign min_vec  = {4'b0, masks.minute_mask};
	assign wday_vec = {1'b0, masks.weekday_mask};

	assign mon_hit  = mon_vec[cal.mon];
	assign day_hit  = masks.month_day_mask[cal.mday] && wday_vec[cal.wday];
	assign hour_hit = hour_vec[cal.hour];
	assign min_hit  = min_vec[cal.minute];

	assign mlen      = cnm_pkg::month_len(cal.mon, cal.leap);
	assign leap_next = cnm_pkg::is_leap(cal.year + YW'(1));

	// Pick the coarsest failing field
	always_comb begin
		if (!mon_hit) begin
			kind = cnm_pkg::STEP_MONTH;
		end else if (!day_hit) begin
			kind = cnm_pkg::STEP_DAY;
		end else if (!hour_hit) begin
			kind = cnm_pkg::STEP_HOUR;
		end else if (!min_hit) begin
			kind = cnm_pkg::STEP_MINUTE;
		end else begin
			kind = cnm_pkg::STEP_MATCH;
		end
	end

	assign min_roll = cal.minute >= cnm_pkg::LAST_MINUTE;

	// Seconds to the start of the next month, day or hour
	assign days_u    = {2'b0, mlen} - {2'b0, cal.mday} + 7'd1;
	assign day_part  = DW'($signed(days_u)) * cnm_pkg::DAY_SECS_S;
	assign hour_part = $signed(DW'(cal.hour)) * cnm_pkg::HOUR_SECS_S;
	assign min_part  = $signed(DW'(cal.minute)) * cnm_pkg::MIN_SECS_S;

	always_comb begin
		case (kind)
			cnm_pkg::STEP_MONTH:  delta = day_part - hour_part - min_part;
			cnm_pkg::STEP_DAY:    delta = cnm_pkg::DAY_SECS_S - hour_part - min_part;
			cnm_pkg::STEP_HOUR:   delta = cnm_pkg::HOUR_SECS_S - min_part;
			cnm_pkg::STEP_MINUTE: delta = min_roll ? cnm_pkg::HOUR_SECS_S - min_part
			                                       : cnm_pkg::MIN_SECS_S;
			default:              delta = '0;
		endcase
	end

	assign step = {kind, delta};

	// Carry chain from minute up to year
	assign min_inc   = cal.minute + 6'd1;
	assign hour_inc  = {1'b0, cal.hour} + 6'd1;
	assign mday_inc  = {1'b0, cal.mday} + 6'd1;
	assign mon_inc   = {1'b0, cal.mon} + 5'd1;
	assign hour_roll = hour_inc >= cnm_pkg::HOURS_PER_DAY;
	assign mday_roll = mday_inc > {1'b0, mlen};
	assign year_roll = mon_inc >= {1'b0, cnm_pkg::MONTHS_PER_YEAR};

	assign do_hour  = (kind == cnm_pkg::STEP_HOUR) ||
	                  ((kind == cnm_pkg::STEP_MINUTE) && min_roll);
	assign do_day   = (kind == cnm_pkg::STEP_DAY) || (do_hour && hour_roll);
	assign do_month = (kind == cnm_pkg::STEP_MONTH) || (do_day && mday_roll);

	always_comb begin
		nxt = cal;
		if ((kind == cnm_pkg::STEP_MINUTE) && !min_roll) begin
			nxt.minute = min_inc;
		end
		if (do_hour) begin
			nxt.minute = '0;
			nxt.hour   = hour_inc[4:0];
		end
		if (do_day) begin
			nxt.minute = '0;
			nxt.hour   = '0;
			nxt.mday   = mday_inc[4:0];
			nxt.wday   = cnm_pkg::mod7({3'b0, cal.wday} + 6'd1);
		end
		if (do_month) begin
			nxt.minute = '0;
			nxt.hour   = '0;
			nxt.mday   = 5'd1;
			nxt.wday   = cnm_pkg::mod7({3'b0, cal.wday} + {1'b0, mlen} + 6'd8
			                           - {1'b0, cal.mday});
			if (year_roll) begin
				nxt.mon  = '0;
				nxt.year = cal.year + YW'(1);
				nxt.leap = leap_next;
			end else begin
				nxt.mon = mon_inc[3:0];
			end
		end
	end

endmodule

// ===== hw/rtl/cnm_time_unit.sv =====
`timescale 1ns / 1ps

module cnm_time_unit #(
	parameter logic signed [cnm_pkg::TIME_W-1:0] SPAN = '0
) (
	input  logic                                 clk,
	input  logic                                 load,
	input  logic [39:0]                          load_time,
	input  logic [5:0]                           load_sec,
	input  logic                                 advance,
	input  logic signed [cnm_pkg::DELTA_W-1:0]   delta,
	output logic [39:0]                          cur_time,
	output logic                                 expired
);

	localparam int TW = cnm_pkg::TIME_W;

	logic signed [TW-1:0] t_q;
	logic signed [TW-1:0] limit_q;

	// Load the truncated start and the search limit, then accumulate step deltas
	always_ff @(posedge clk) begin
		if (load) begin
			t_q     <= $signed(TW'(load_time)) - $signed(TW'(load_sec));
			limit_q <= $signed(TW'(load_time)) + SPAN;
		end else if (advance) begin
			t_q <= t_q + TW'(delta);
		end
	end

	assign expired  = !(t_q < limit_q);
	assign cur_time = t_q[39:0];

endmodule

// ===== hw/rtl/cron_next_match_search.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Payload                                  Transfer
// query     in   start time, calendar fields of start     valid & ready
// result    out  found, matching time and calendar fields valid & ready
// cfg_*     in   mask register write                      cfg_wr_en
//
// Each step moves the calendar and time; the result loads once the search ends
// with the output register free, and the next query can transfer after that.
// With an empty minute mask every minute of a matching day is a step: 1440 a day,
// about 5.3 million over the 366 * SEARCH_YEARS day window.
// Reset restores the default masks and empties the output register.
// Query is ready only while idle; a finished search holds until the output frees.

module cron_next_match_search #(
	parameter int SEARCH_YEARS = 10
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [cnm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [cnm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	cnm_stream_if.sink                         query,
	cnm_stream_if.source                       result
);

	localparam int TW = cnm_pkg::TIME_W;
	localparam int YW = cnm_pkg::YEAR_W;
	localparam logic signed [TW-1:0] LIMIT_SPAN =
		TW'(366 * cnm_pkg::SECS_PER_DAY * SEARCH_YEARS);

	typedef enum logic {
		ST_IDLE,
		ST_SEARCH
	} state_t;

	state_t            state_q;
	cnm_pkg::masks_t   masks_q;
	cnm_pkg::cal_t     cal_q;
	cnm_pkg::cal_t     cal_nxt;
	cnm_pkg::step_t    step;
	cnm_pkg::cnm_out_t out_q;
	logic              out_valid_q;
	logic              in_xfer, out_xfer, out_free;
	logic              finish, advance, expired;
	logic [39:0]       cur_time;

	assign query.ready    = (state_q == ST_IDLE);
	assign in_xfer        = query.valid && query.ready;
	assign result.valid   = out_valid_q;
	assign result.payload = out_q;
	assign out_xfer       = out_valid_q && result.ready;
	assign out_free       = !out_valid_q || result.ready;

	assign finish  = expired || (step.kind == cnm_pkg::STEP_MATCH);
	assign advance = (state_q == ST_SEARCH) && !finish;

	// Mask registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			masks_q.minute_mask    <= cnm_pkg::MINUTE_MASK_RST;
			masks_q.hour_mask      <= cnm_pkg::HOUR_MASK_RST;
			masks_q.month_day_mask <= cnm_pkg::MONTH_DAY_MASK_RST;
			masks_q.weekday_mask   <= cnm_pkg::WEEKDAY_MASK_RST;
			masks_q.month_mask     <= cnm_pkg::MONTH_MASK_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				cnm_pkg::REG_MINUTE_MASK:    masks_q.minute_mask    <= cfg_wdata[59:0];
				cnm_pkg::REG_HOUR_MASK:      masks_q.hour_mask      <= cfg_wdata[23:0];
				cnm_pkg::REG_MONTH_DAY_MASK: masks_q.month_day_mask <= cfg_wdata[31:0];
				cnm_pkg::REG_WEEKDAY_MASK:   masks_q.weekday_mask   <= cfg_wdata[6:0];
				cnm_pkg::REG_MONTH_MASK:     masks_q.month_mask     <= cfg_wdata[11:0];
				default: ;
			endcase
		end
	end

	// Calendar position of the search
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cal_q.year   <= YW'(query.payload.start_year);
			cal_q.leap   <= cnm_pkg::is_leap(YW'(query.payload.start_year));
			cal_q.mon    <= query.payload.start_month;
			cal_q.mday   <= query.payload.start_mday;
			cal_q.wday   <= query.payload.start_wday;
			cal_q.hour   <= query.payload.start_hour;
			cal_q.minute <= query.payload.start_minute;
		end else if (advance) begin
			cal_q <= cal_nxt;
		end
	end

	cnm_cal_step u_step (
		.cal   (cal_q),
		.masks (masks_q),
		.step  (step),
		.nxt   (cal_nxt)
	);

	cnm_time_unit #(
		.SPAN (LIMIT_SPAN)
	) u_time (
		.clk       (clk),
		.load      (in_xfer),
		.load_time (query.payload.start_time),
		.load_sec  (query.payload.start_second),
		.advance   (advance),
		.delta     (step.delta),
		.cur_time  (cur_time),
		.expired   (expired)
	);

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (out_xfer) begin
						out_valid_q <= 1'b0;
					end
					if (in_xfer) begin
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (finish && out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
						if (expired) begin
							out_q <= '0;
						end else begin
							out_q.found       <= 1'b1;
							out_q.next_time   <= cur_time;
							out_q.next_year   <= cal_q.year[11:0];
							out_q.next_month  <= cal_q.mon;
							out_q.next_mday   <= cal_q.mday;
							out_q.next_wday   <= cal_q.wday;
							out_q.next_hour   <= cal_q.hour;
							out_q.next_minute <= cal_q.minute;
						end
					end else if (out_xfer) begin
						out_valid_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_busy_after_query: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !query.ready)
		else $error("query taken while a search was starting");

	a_miss_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.found) |-> (out_q.next_time == '0 && out_q.next_year == '0 &&
		 out_q.next_month == '0 && out_q.next_mday == '0 && out_q.next_wday == '0 &&
		 out_q.next_hour == '0 && out_q.next_minute == '0))
		else $error("miss result carries nonzero fields");

	a_result_from_search: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_SEARCH))
		else $error("result loaded outside a search");

	a_hold_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH && finish && !out_free) |=> $stable(cal_q))
		else $error("calendar moved while result was blocked");

	a_step_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (cal_q.mon < cnm_pkg::MONTHS_PER_YEAR && 6'(cal_q.hour) < cnm_pkg::HOURS_PER_DAY
		 && cal_q.minute <= cnm_pkg::LAST_MINUTE && cal_q.wday < cnm_pkg::DAYS_PER_WEEK))
		else $error("search step left a field out of range");
`endif

endmodule

// ===== tb/cnm_match_checker.sv =====
`timescale 1ns / 1ps

module cnm_match_checker #(
	parameter int SEARCH_YEARS = 10
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [cnm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cnm_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                           query_valid,
	input  logic                           query_ready,
	input  cnm_pkg::cnm_in_t               query_data,
	input  logic                           result_valid,
	input  logic                           result_ready,
	input  cnm_pkg::cnm_out_t              result_data,
	output int                             mismatches,
	output int                             outstanding
);

	typedef struct {
		longint year;
		longint mon;
		longint mday;
		longint wday;
		longint hour;
		longint minute;
	} cal_date_t;

	// Mask copies, zero-extended so that bits past a register's width read as 0
	logic [63:0] allowed_minutes;
	logic [63:0] allowed_hours;
	logic [63:0] allowed_mdays;
	logic [63:0] allowed_wdays;
	logic [63:0] allowed_months;

	cnm_pkg::cnm_out_t expected_matches[$];
	cnm_pkg::cnm_out_t want;
	int                error_count = 0;
	int                pending_q = 0;

	assign mismatches  = error_count;
	assign outstanding = pending_q;

	function automatic logic mask_bit(input logic [63:0] m, input longint idx);
		if (idx < 0 || idx > 63) begin
			return 1'b0;
		end
		return m[idx];
	endfunction

	function automatic longint month_days(input longint mon, input longint year);
		if (mon == int'(cnm_pkg::MON_FEB)) begin
			return ((year % 4 == 0) && (year % 100 != 0 || year % 400 == 0)) ? 29 : 28;
		end
		if (mon == int'(cnm_pkg::MON_APR) || mon == int'(cnm_pkg::MON_JUN) ||
				mon == int'(cnm_pkg::MON_SEP) || mon == int'(cnm_pkg::MON_NOV)) begin
			return 30;
		end
		return 31;
	endfunction

	function automatic longint wrap_week(input longint v);
		longint r;
		r = v % int'(cnm_pkg::DAYS_PER_WEEK);
		return (r < 0) ? r + int'(cnm_pkg::DAYS_PER_WEEK) : r;
	endfunction

	function automatic cal_date_t roll_month(input cal_date_t d);
		d.wday   = wrap_week(d.wday + month_days(d.mon, d.year) - (d.mday - 1));
		d.mday   = 1;
		d.hour   = 0;
		d.minute = 0;
		d.mon++;
		if (d.mon >= int'(cnm_pkg::MONTHS_PER_YEAR)) begin
			d.mon = 0;
			d.year++;
		end
		return d;
	endfunction

	function automatic cal_date_t roll_day(input cal_date_t d);
		d.hour   = 0;
		d.minute = 0;
		d.wday   = wrap_week(d.wday + 1);
		d.mday++;
		if (d.mday > month_days(d.mon, d.year)) begin
			d = roll_month(d);
		end
		return d;
	endfunction

	function automatic cal_date_t roll_hour(input cal_date_t d);
		d.minute = 0;
		d.hour++;
		if (d.hour >= int'(cnm_pkg::HOURS_PER_DAY)) begin
			d = roll_day(d);
		end
		return d;
	endfunction

	// Walk forward from the start minute, skipping whole units on coarse misses
	function automatic cnm_pkg::cnm_out_t search_next_match(input cnm_pkg::cnm_in_t q);
		cal_date_t         d;
		longint            t;
		longint            t_end;
		longint            start;
		longint            sec;
		cnm_pkg::cnm_out_t r;
		start    = q.start_time;
		sec      = q.start_second;
		d.year   = q.start_year;
		d.mon    = q.start_month;
		d.mday   = q.start_mday;
		d.wday   = q.start_wday;
		d.hour   = q.start_hour;
		d.minute = q.start_minute;
		t        = start - sec;
		t_end    = start + longint'(366) * cnm_pkg::SECS_PER_DAY * SEARCH_YEARS;
		r        = '0;
		do begin
			if (!mask_bit(allowed_months, d.mon)) begin
				t += (month_days(d.mon, d.year) - (d.mday - 1)) * cnm_pkg::SECS_PER_DAY
					- d.hour * cnm_pkg::SECS_PER_HOUR - d.minute * cnm_pkg::SECS_PER_MIN;
				d = roll_month(d);
			end else if (!mask_bit(allowed_mdays, d.mday) ||
					!mask_bit(allowed_wdays, d.wday)) begin
				t += cnm_pkg::SECS_PER_DAY - d.hour * cnm_pkg::SECS_PER_HOUR
					- d.minute * cnm_pkg::SECS_PER_MIN;
				d = roll_day(d);
			end else if (!mask_bit(allowed_hours, d.hour)) begin
				t += cnm_pkg::SECS_PER_HOUR - d.minute * cnm_pkg::SECS_PER_MIN;
				d = roll_hour(d);
			end else if (!mask_bit(allowed_minutes, d.minute)) begin
				t += cnm_pkg::SECS_PER_MIN;
				d.minute++;
				if (d.minute > int'(cnm_pkg::LAST_MINUTE)) begin
					t += cnm_pkg::SECS_PER_HOUR - d.minute * cnm_pkg::SECS_PER_MIN;
					d = roll_hour(d);
				end
			end else begin
				r.found       = 1'b1;
				r.next_time   = t[39:0];
				r.next_year   = d.year[11:0];
				r.next_month  = d.mon[3:0];
				r.next_mday   = d.mday[4:0];
				r.next_wday   = d.wday[2:0];
				r.next_hour   = d.hour[4:0];
				r.next_minute = d.minute[5:0];
				return r;
			end
		end while (t < t_end);
		return r;
	endfunction

	// Print one line per mismatch and count it
	task automatic report(input string msg);
		error_count++;
		$display("%0t ns checker error: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [39:0] got,
			input logic [39:0] exp_val);
		if (got !== exp_val) begin
			report($sformatf("%s got %0h, expected %0h", name, got, exp_val));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_matches.delete();
			allowed_minutes = 64'(cnm_pkg::MINUTE_MASK_RST);
			allowed_hours   = 64'(cnm_pkg::HOUR_MASK_RST);
			allowed_mdays   = 64'(cnm_pkg::MONTH_DAY_MASK_RST);
			allowed_wdays   = 64'(cnm_pkg::WEEKDAY_MASK_RST);
			allowed_months  = 64'(cnm_pkg::MONTH_MASK_RST);
		end else begin
			// Predict each accepted query with the masks in force
			if (query_valid && query_ready) begin
				expected_matches.push_back(search_next_match(query_data));
			end
			// Compare each result transfer against the oldest prediction
			if (result_valid && result_ready) begin
				if (expected_matches.size() == 0) begin
					report("result transfer with no query outstanding");
				end else begin
					want = expected_matches.pop_front();
					check_field("found", 40'(result_data.found), 40'(want.found));
					check_field("next_time", result_data.next_time, want.next_time);
					check_field("next_year", 40'(result_data.next_year), 40'(want.next_year));
					check_field("next_month", 40'(result_data.next_month),
						40'(want.next_month));
					check_field("next_mday", 40'(result_data.next_mday), 40'(want.next_mday));
					check_field("next_wday", 40'(result_data.next_wday), 40'(want.next_wday));
					check_field("next_hour", 40'(result_data.next_hour), 40'(want.next_hour));
					check_field("next_minute", 40'(result_data.next_minute),
						40'(want.next_minute));
				end
			end
			// Track mask writes; indexes past the list are dropped
			if (cfg_wr_en) begin
				case (cfg_index)
					cnm_pkg::REG_MINUTE_MASK:    allowed_minutes = 64'(cfg_wdata[59:0]);
					cnm_pkg::REG_HOUR_MASK:      allowed_hours   = 64'(cfg_wdata[23:0]);
					cnm_pkg::REG_MONTH_DAY_MASK: allowed_mdays   = 64'(cfg_wdata[31:0]);
					cnm_pkg::REG_WEEKDAY_MASK:   allowed_wdays   = 64'(cfg_wdata[6:0]);
					cnm_pkg::REG_MONTH_MASK:     allowed_months  = 64'(cfg_wdata[11:0]);
					default: ;
				endcase
			end
		end
		pending_q <= expected_matches.size();
	end

endmodule

// ===== tb/tb_cron_next_match_search.sv =====
`timescale 1ns / 1ps

module tb_cron_next_match_search;

	localparam int SEARCH_YEARS = 10;
	localparam int HOLD_CYCLES  = 300;
	localparam logic [cnm_pkg::CFG_IDX_W-1:0] REG_PAST_END = 3'd5;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_wr_en;
	logic [cnm_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [cnm_pkg::CFG_DATA_W-1:0] cfg_wdata;

	int   fail_count;
	int   pending;
	int   result_hold = 0;
	logic hold_req = 1'b0;
	logic steady = 1'b0;

	cnm_stream_if #(.payload_t(cnm_pkg::cnm_in_t))  query_ch ();
	cnm_stream_if #(.payload_t(cnm_pkg::cnm_out_t)) result_ch ();

	cron_next_match_search #(.SEARCH_YEARS(SEARCH_YEARS)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.query     (query_ch),
		.result    (result_ch)
	);

	cnm_match_checker #(.SEARCH_YEARS(SEARCH_YEARS)) chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.query_valid  (query_ch.valid),
		.query_ready  (query_ch.ready),
		.query_data   (query_ch.payload),
		.result_valid (result_ch.valid),
		.result_ready (result_ch.ready),
		.result_data  (result_ch.payload),
		.mismatches   (fail_count),
		.outstanding  (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#60_000_000;
		$display("FAIL");
		$finish;
	end

	// Result side: long hold-off on request, else random stalls unless steady
	always @(posedge clk) begin
		if (hold_req && result_hold < HOLD_CYCLES) begin
			result_ch.ready <= 1'b0;
			result_hold     <= result_hold + 1;
		end else if (steady) begin
			result_ch.ready <= 1'b1;
		end else begin
			result_ch.ready <= ($urandom_range(99) >= 29);
		end
	end

	function automatic cnm_pkg::cnm_in_t make_query(input logic [39:0] st,
			input logic [11:0] yr, input logic [3:0] mon, input logic [4:0] mday,
			input logic [2:0] wday, input logic [4:0] hr, input logic [5:0] mn,
			input logic [5:0] sec);
		cnm_pkg::cnm_in_t q;
		q.start_time   = st;
		q.start_year   = yr;
		q.start_month  = mon;
		q.start_mday   = mday;
		q.start_wday   = wday;
		q.start_hour   = hr;
		q.start_minute = mn;
		q.start_second = sec;
		return q;
	endfunction

	// Mostly legal values, sometimes any value the field width holds
	function automatic int field_val(input int lo, input int hi, input int w);
		if ($urandom_range(99) < 88) begin
			return $urandom_range(hi, lo);
		end
		return $urandom & ((1 << w) - 1);
	endfunction

	function automatic cnm_pkg::cnm_in_t random_query();
		logic [63:0] st;
		st = {$urandom, $urandom};
		return make_query(st[39:0], 12'(field_val(1900, 4085, 12)),
			4'(field_val(0, 11, 4)), 5'(field_val(1, 31, 5)), 3'(field_val(0, 6, 3)),
			5'(field_val(0, 23, 5)), 6'(field_val(0, 59, 6)), 6'(field_val(0, 60, 6)));
	endfunction

	function automatic logic [63:0] few_bits(input int top);
		logic [63:0] m;
		m = 64'(1) << $urandom_range(top);
		if ($urandom_range(1) == 1) begin
			m = m | (64'(1) << $urandom_range(top));
		end
		return m;
	endfunction

	// Offer one query and hold it until the transfer
	task automatic send_query(input cnm_pkg::cnm_in_t item);
		while (!steady && $urandom_range(99) < 29) begin
			query_ch.valid <= 1'b0;
			@(posedge clk);
		end
		query_ch.valid   <= 1'b1;
		query_ch.payload <= item;
		do @(posedge clk); while (!query_ch.ready);
	endtask

	task automatic random_burst(input int n);
		repeat (n) send_query(random_query());
	endtask

	// Drop valid and wait until every result has been checked
	task automatic settle();
		query_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [cnm_pkg::CFG_IDX_W-1:0] idx,
			input logic [59:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
	endtask

	// Write all five masks, plus one stray write past the register list
	task automatic load_masks(input logic [59:0] mins, input logic [59:0] hrs,
			input logic [59:0] mdays, input logic [59:0] wdays, input logic [59:0] months);
		logic [63:0] junk;
		junk = {$urandom, $urandom};
		write_reg(cnm_pkg::REG_MINUTE_MASK, mins);
		write_reg(cnm_pkg::REG_HOUR_MASK, hrs);
		write_reg(cnm_pkg::REG_MONTH_DAY_MASK, mdays);
		write_reg(cnm_pkg::REG_WEEKDAY_MASK, wdays);
		write_reg(cnm_pkg::REG_MONTH_MASK, months);
		write_reg(REG_PAST_END + cnm_pkg::CFG_IDX_W'($urandom_range(2)), junk[59:0]);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic load_dense_masks();
		logic [63:0] r;
		r = {$urandom, $urandom};
		load_masks(r[59:0] | 60'(few_bits(59)), 60'($urandom & 24'hFF_FFFF) | 60'(few_bits(23)),
			60'($urandom), 60'($urandom_range(127)), 60'($urandom_range(4095)));
	endtask

	task automatic load_sparse_masks();
		load_masks(60'(few_bits(59)), 60'(few_bits(23)), 60'(few_bits(31)),
			60'(few_bits(6)), 60'(few_bits(11)));
	endtask

	initial begin
		arst_n           <= 1'b0;
		cfg_wr_en        <= 1'b0;
		cfg_index        <= '0;
		cfg_wdata        <= '0;
		query_ch.valid   <= 1'b0;
		query_ch.payload <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset masks: bounds, second truncation, out-of-range fields, wraps
		send_query(make_query(40'd0, 12'd1900, 4'd0, 5'd1, 3'd1, 5'd0, 6'd0, 6'd0));
		send_query(make_query(40'hFF_FFFF_FFFF, 12'd4085, 4'd11, 5'd31, 3'd6, 5'd23, 6'd59,
			6'd60));
		send_query(make_query(40'd0, 12'd1970, 4'd0, 5'd1, 3'd4, 5'd0, 6'd0, 6'd30));
		send_query(make_query(40'd1000000, 12'd2001, 4'd5, 5'd0, 3'd3, 5'd10, 6'd20, 6'd5));
		send_query(make_query(40'd12345678, 12'd4095, 4'd15, 5'd31, 3'd7, 5'd31, 6'd63,
			6'd63));
		send_query(make_query(40'd500000, 12'd2023, 4'd12, 5'd15, 3'd2, 5'd8, 6'd0, 6'd0));
		send_query(make_query(40'd777777, 12'd2010, 4'd3, 5'd31, 3'd0, 5'd24, 6'd0, 6'd0));
		send_query(make_query(40'd888888, 12'd2010, 4'd6, 5'd10, 3'd5, 5'd12, 6'd60, 6'd0));
		send_query(make_query(40'h80_0000_0000, 12'd2400, 4'd1, 5'd29, 3'd2, 5'd0, 6'd0,
			6'd59));
		send_query(make_query(40'd99999, 12'd2015, 4'd7, 5'd20, 3'd7, 5'd6, 6'd30, 6'd0));
		settle();

		// Empty masks: no minute can match anywhere in the window
		load_masks('0, '0, '0, '0, '0);
		send_query(make_query(40'd0, 12'd1900, 4'd0, 5'd1, 3'd1, 5'd0, 6'd0, 6'd0));
		send_query(make_query(40'hFF_FFFF_FFFF, 12'd4085, 4'd11, 5'd31, 3'd6, 5'd23, 6'd59,
			6'd60));
		random_burst(5);
		settle();

		// February 29 only: leap years, centuries and a nonexistent start day
		load_masks('1, '1, 60'(32'd1 << 29), 60'(7'h7F), 60'(12'd1 << cnm_pkg::MON_FEB));
		send_query(make_query(40'd0, 12'd1900, 4'd1, 5'd1, 3'd4, 5'd0, 6'd0, 6'd0));
		send_query(make_query(40'd100, 12'd2000, 4'd1, 5'd1, 3'd2, 5'd0, 6'd0, 6'd0));
		send_query(make_query(40'd200, 12'd2100, 4'd1, 5'd1, 3'd1, 5'd0, 6'd0, 6'd0));
		send_query(make_query(40'd300, 12'd2096, 4'd2, 5'd1, 3'd4, 5'd0, 6'd0, 6'd0));
		send_query(make_query(40'd400, 12'd2023, 4'd1, 5'd29, 3'd3, 5'd12, 6'd0, 6'd0));
		settle();

		// Full masks, with a long result hold-off so the input backs up
		load_masks('1, '1, '1, '1, '1);
		hold_req <= 1'b1;
		random_burst(20);
		settle();

		repeat (3) begin
			load_dense_masks();
			random_burst(20);
			settle();
		end

		repeat (2) begin
			load_sparse_masks();
			random_burst(20);
			settle();
		end

		// Run back to back with no gaps on either side
		steady = 1'b1;
		load_dense_masks();
		random_burst(20);
		settle();
		steady = 1'b0;

		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
